>>> rtl/lbpg_pkg.sv
// shared types and codes for the led and buzzer pattern generator
package lbpg_pkg;

    // configuration register indexes (byte address is 4 times the index)
    typedef enum logic [2:0] {
        REG_PATTERN_MODE  = 3'd0,
        REG_MANUAL_RED    = 3'd1,
        REG_MANUAL_GREEN  = 3'd2,
        REG_MANUAL_BLUE   = 3'd3,
        REG_MANUAL_BUZ_ON = 3'd4,
        REG_MANUAL_FREQ   = 3'd5
    } t_reg_idx;

    // background modes, codes above manual behave as manual
    typedef enum logic [2:0] {
        MODE_NORMAL      = 3'd0,
        MODE_FLYING      = 3'd1,
        MODE_PROCESSING1 = 3'd2,
        MODE_PROCESSING2 = 3'd3,
        MODE_MANUAL      = 3'd4
    } t_mode;

    // input operations
    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_TRIGGER = 1'b1
    } t_op;

    // one-shot signal kinds
    typedef enum logic [2:0] {
        SIG_START1    = 3'd0,
        SIG_START2    = 3'd1,
        SIG_CONTINUE1 = 3'd2,
        SIG_SUCCESS1  = 3'd3,
        SIG_ERR1      = 3'd4
    } t_sig_kind;

    localparam int unsigned PCT_W  = 7;
    localparam int unsigned FREQ_W = 16;
    localparam int unsigned STIM_W = 7;
    localparam int unsigned PTIM_W = 8;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [PCT_W-1:0]  PCT_FULL = 7'd100;

    localparam logic [FREQ_W-1:0] FREQ_800  = 16'd800;
    localparam logic [FREQ_W-1:0] FREQ_900  = 16'd900;
    localparam logic [FREQ_W-1:0] FREQ_1000 = 16'd1000;
    localparam logic [FREQ_W-1:0] FREQ_1200 = 16'd1200;
    localparam logic [FREQ_W-1:0] FREQ_1500 = 16'd1500;

    // one-shot lengths in ticks
    localparam logic [STIM_W-1:0] LEN_START1    = 7'd30;
    localparam logic [STIM_W-1:0] LEN_START2    = 7'd45;
    localparam logic [STIM_W-1:0] LEN_CONTINUE1 = 7'd80;
    localparam logic [STIM_W-1:0] LEN_SUCCESS1  = 7'd80;
    localparam logic [STIM_W-1:0] LEN_ERR1      = 7'd100;

    // result beat
    typedef struct packed {
        logic [PCT_W-1:0]  red;
        logic [PCT_W-1:0]  green;
        logic [PCT_W-1:0]  blue;
        logic              buz_on;
        logic [FREQ_W-1:0] freq;
        logic              busy;
    } t_result;

endpackage

>>> rtl/led_buzzer_pattern_generator_unit.sv
// top level of the led and buzzer pattern generator
//
// Each input beat is one 10 ms tick or a one-shot trigger and produces exactly one
// result beat holding the led percentages, buzzer enable and frequency and the
// busy flag after that beat. The whole update is combinational logic from the state
// registers into a result register, so one beat is taken every clock while o_stall is
// low. A two-entry output buffer (result register plus skid register) lets the block
// take a beat while a result still waits; o_stall rises only when both entries are full.
// Configuration is written through the APB-style port with zero wait states; the user
// must write it only while the block is idle, which the block itself does not enforce.
module led_buzzer_pattern_generator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // apb configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lbpg_pkg::ADDR_W-1:0]  paddr,
    input  logic [lbpg_pkg::DATA_W-1:0]  pwdata,
    output logic [lbpg_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    // input channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_operation,
    input  logic [2:0]                   i_signal_kind,
    // output channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [lbpg_pkg::PCT_W-1:0]   o_led_red,
    output logic [lbpg_pkg::PCT_W-1:0]   o_led_green,
    output logic [lbpg_pkg::PCT_W-1:0]   o_led_blue,
    output logic                         o_buzzer_on,
    output logic [lbpg_pkg::FREQ_W-1:0]  o_buzzer_freq,
    output logic                         o_signal_busy
);
    import lbpg_pkg::*;

    // configuration registers
    logic [2:0]        r_mode;
    logic [PCT_W-1:0]  r_man_red;
    logic [PCT_W-1:0]  r_man_green;
    logic [PCT_W-1:0]  r_man_blue;
    logic              r_man_buz_on;
    logic [FREQ_W-1:0] r_man_freq;

    // pattern state
    logic              r_sig_active;
    logic [STIM_W-1:0] r_sig_timer;
    logic [2:0]        r_sig_held;
    logic [PTIM_W-1:0] r_pat_timer;
    logic [PCT_W-1:0]  r_red;
    logic [PCT_W-1:0]  r_green;
    logic [PCT_W-1:0]  r_blue;
    logic              r_buz;
    logic [FREQ_W-1:0] r_freq;

    logic              n_sig_active;
    logic [STIM_W-1:0] n_sig_timer;
    logic [2:0]        n_sig_held;
    logic [PTIM_W-1:0] n_pat_timer;
    logic [PCT_W-1:0]  n_red;
    logic [PCT_W-1:0]  n_green;
    logic [PCT_W-1:0]  n_blue;
    logic              n_buz;
    logic [FREQ_W-1:0] n_freq;

    // output buffer
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result n_res;

    logic              w_in_acc;
    logic              w_out_acc;
    logic              w_cfg_wr;
    t_reg_idx          w_cfg_idx;
    logic [STIM_W-1:0] w_sig_len;
    logic [PTIM_W-1:0] w_c;
    logic [12:0]       w_fly_gnum;
    logic [12:0]       w_fly_bnum;
    logic [23:0]       w_fly_gprod;
    logic [23:0]       w_fly_bprod;
    logic [PCT_W-1:0]  w_fly_green;
    logic [PCT_W-1:0]  w_fly_blue;
    logic [PTIM_W-1:0] w_c4;
    logic [PTIM_W-1:0] w_c4m;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = r_out_valid && !i_stall;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    // apb write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_PROCESSING1;
            r_man_red    <= '0;
            r_man_green  <= '0;
            r_man_blue   <= '0;
            r_man_buz_on <= 1'b0;
            r_man_freq   <= '0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_PATTERN_MODE:  r_mode       <= pwdata[2:0];
                REG_MANUAL_RED:    r_man_red    <= pwdata[PCT_W-1:0];
                REG_MANUAL_GREEN:  r_man_green  <= pwdata[PCT_W-1:0];
                REG_MANUAL_BLUE:   r_man_blue   <= pwdata[PCT_W-1:0];
                REG_MANUAL_BUZ_ON: r_man_buz_on <= pwdata[0];
                REG_MANUAL_FREQ:   r_man_freq   <= pwdata[FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    // apb read
    assign pready = 1'b1;
    always_comb begin
        case (w_cfg_idx)
            REG_PATTERN_MODE:  prdata = {{(DATA_W-3){1'b0}}, r_mode};
            REG_MANUAL_RED:    prdata = {{(DATA_W-PCT_W){1'b0}}, r_man_red};
            REG_MANUAL_GREEN:  prdata = {{(DATA_W-PCT_W){1'b0}}, r_man_green};
            REG_MANUAL_BLUE:   prdata = {{(DATA_W-PCT_W){1'b0}}, r_man_blue};
            REG_MANUAL_BUZ_ON: prdata = {{(DATA_W-1){1'b0}}, r_man_buz_on};
            REG_MANUAL_FREQ:   prdata = {{(DATA_W-FREQ_W){1'b0}}, r_man_freq};
            default:           prdata = '0;
        endcase
    end

    // one-shot length, held kinds above err1 fold modulo five
    always_comb begin
        case (r_sig_held)
            3'd0, 3'd5: w_sig_len = LEN_START1;
            3'd1, 3'd6: w_sig_len = LEN_START2;
            3'd2, 3'd7: w_sig_len = LEN_CONTINUE1;
            3'd3:       w_sig_len = LEN_SUCCESS1;
            default:    w_sig_len = LEN_ERR1;
        endcase
    end

    // background timer after the per-mode wrap check
    always_comb begin
        case (r_mode)
            MODE_NORMAL:      w_c = (r_pat_timer > 8'd200) ? '0 : r_pat_timer;
            MODE_FLYING:      w_c = (r_pat_timer > 8'd140) ? '0 : r_pat_timer;
            MODE_PROCESSING1,
            MODE_PROCESSING2: w_c = (r_pat_timer > 8'd50) ? '0 : r_pat_timer;
            default:          w_c = r_pat_timer;
        endcase
    end

    // flying ramp: floor(30x/100) as multiply by 1311 and shift by 17
    assign w_fly_gnum  = 13'(w_c) * 13'd30;
    assign w_fly_bnum  = 13'(8'd100 - w_c) * 13'd30;
    assign w_fly_gprod = 24'(w_fly_gnum) * 24'd1311;
    assign w_fly_bprod = 24'(w_fly_bnum) * 24'd1311;
    assign w_fly_green = w_fly_gprod[17 +: PCT_W];
    assign w_fly_blue  = w_fly_bprod[17 +: PCT_W];

    // processing2 ramp terms
    assign w_c4  = {w_c[PTIM_W-3:0], 2'b00};
    assign w_c4m = {w_c[PTIM_W-3:0] - 6'd25, 2'b00};

    // next state for one beat
    always_comb begin
        n_sig_active = r_sig_active;
        n_sig_timer  = r_sig_timer;
        n_sig_held   = r_sig_held;
        n_pat_timer  = r_pat_timer;
        n_red        = r_red;
        n_green      = r_green;
        n_blue       = r_blue;
        n_buz        = r_buz;
        n_freq       = r_freq;
        if (i_operation == OP_TRIGGER) begin
            // unknown kinds are ignored
            if (i_signal_kind <= SIG_ERR1) begin
                n_sig_timer  = '0;
                n_sig_held   = i_signal_kind;
                n_sig_active = 1'b1;
            end
        end else if (r_sig_active) begin
            if (r_sig_timer > w_sig_len) begin
                // end of signal, drives hold
                n_sig_active = 1'b0;
            end else begin
                n_sig_timer = r_sig_timer + 7'd1;
                case (r_sig_held)
                    3'd0, 3'd5: begin
                        n_buz = 1'b1;
                        n_red = '0;
                        if (r_sig_timer < 7'd15) begin
                            n_freq  = FREQ_900;
                            n_green = '0;
                            n_blue  = PCT_FULL;
                        end else begin
                            n_freq  = FREQ_1500;
                            n_green = PCT_FULL;
                            n_blue  = '0;
                        end
                    end
                    3'd1, 3'd6: begin
                        n_buz   = 1'b1;
                        n_red   = '0;
                        n_green = '0;
                        n_blue  = '0;
                        if (r_sig_timer < 7'd15) begin
                            n_freq = FREQ_800;
                            n_red  = PCT_FULL;
                        end else if (r_sig_timer < 7'd30) begin
                            n_freq  = FREQ_1000;
                            n_green = PCT_FULL;
                        end else begin
                            n_freq = FREQ_1200;
                            n_blue = PCT_FULL;
                        end
                    end
                    3'd2, 3'd7: begin
                        // buzzer holds in the second half
                        n_freq  = FREQ_1500;
                        n_red   = '0;
                        n_green = '0;
                        n_blue  = '0;
                        if (r_sig_timer < 7'd20) begin
                            n_blue = PCT_FULL;
                            n_buz  = 1'b1;
                        end else if (r_sig_timer < 7'd40) begin
                            n_buz = 1'b0;
                        end else if (r_sig_timer < 7'd60) begin
                            n_blue = PCT_FULL;
                        end
                    end
                    3'd3: begin
                        n_freq  = FREQ_1500;
                        n_red   = '0;
                        n_blue  = '0;
                        if ((r_sig_timer < 7'd20) ||
                            (r_sig_timer >= 7'd40 && r_sig_timer < 7'd60)) begin
                            n_green = PCT_FULL;
                            n_buz   = 1'b1;
                        end else begin
                            n_green = '0;
                            n_buz   = 1'b0;
                        end
                    end
                    default: begin
                        n_buz   = 1'b1;
                        n_freq  = FREQ_800;
                        n_green = '0;
                        n_blue  = '0;
                        if ((r_sig_timer < 7'd25) ||
                            (r_sig_timer >= 7'd50 && r_sig_timer < 7'd75)) begin
                            n_red = PCT_FULL;
                        end else begin
                            n_red = '0;
                        end
                    end
                endcase
            end
        end else begin
            // background pattern
            n_pat_timer = w_c + 8'd1;
            case (r_mode)
                MODE_NORMAL: begin
                    n_buz   = 1'b0;
                    n_red   = '0;
                    n_blue  = '0;
                    n_green = (w_c < 8'd100) ? w_c[PCT_W-1:0]
                                             : PCT_W'(8'd200 - w_c);
                end
                MODE_FLYING: begin
                    n_buz   = 1'b0;
                    n_red   = '0;
                    n_green = '0;
                    if (w_c < 8'd100) begin
                        n_green = w_fly_green;
                        n_blue  = w_fly_blue;
                    end else if (w_c < 8'd110) begin
                        n_blue = PCT_FULL;
                    end else if (w_c < 8'd120) begin
                        n_blue = '0;
                    end else if (w_c < 8'd130) begin
                        n_blue = PCT_FULL;
                    end else begin
                        n_blue = '0;
                    end
                end
                MODE_PROCESSING1: begin
                    n_buz   = 1'b0;
                    n_red   = '0;
                    n_green = '0;
                    n_blue  = {w_c[PCT_W-2:0], 1'b0};
                end
                MODE_PROCESSING2: begin
                    n_buz = 1'b0;
                    n_red = '0;
                    if (w_c < 8'd25) begin
                        n_green = PCT_W'(8'd100 - w_c4);
                        n_blue  = w_c4[PCT_W-1:0];
                    end else begin
                        n_green = w_c4m[PCT_W-1:0];
                        n_blue  = PCT_W'(8'd100 - w_c4m);
                    end
                end
                default: begin
                    // manual, colours saturate at full scale
                    if (r_man_buz_on) begin
                        n_freq = r_man_freq;
                    end
                    n_buz   = r_man_buz_on;
                    n_red   = (r_man_red   > PCT_FULL) ? PCT_FULL : r_man_red;
                    n_green = (r_man_green > PCT_FULL) ? PCT_FULL : r_man_green;
                    n_blue  = (r_man_blue  > PCT_FULL) ? PCT_FULL : r_man_blue;
                end
            endcase
        end
    end

    assign n_res = '{red: n_red, green: n_green, blue: n_blue, buz_on: n_buz,
                     freq: n_freq, busy: n_sig_active};

    // state update on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig_active <= 1'b0;
            r_sig_timer  <= '0;
            r_sig_held   <= '0;
            r_pat_timer  <= '0;
            r_red        <= '0;
            r_green      <= '0;
            r_blue       <= '0;
            r_buz        <= 1'b0;
            r_freq       <= '0;
        end else if (w_in_acc) begin
            r_sig_active <= n_sig_active;
            r_sig_timer  <= n_sig_timer;
            r_sig_held   <= n_sig_held;
            r_pat_timer  <= n_pat_timer;
            r_red        <= n_red;
            r_green      <= n_green;
            r_blue       <= n_blue;
            r_buz        <= n_buz;
            r_freq       <= n_freq;
        end
    end

    // result register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_acc) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_acc;
            end
        end else if (w_in_acc) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_acc) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (w_in_acc && !r_out_valid) begin
            r_out <= n_res;
        end
        if (w_in_acc && r_out_valid && !w_out_acc) begin
            r_skid <= n_res;
        end
    end

    assign o_stall       = r_skid_valid;
    assign o_valid       = r_out_valid;
    assign o_led_red     = r_out.red;
    assign o_led_green   = r_out.green;
    assign o_led_blue    = r_out.blue;
    assign o_buzzer_on   = r_out.buz_on;
    assign o_buzzer_freq = r_out.freq;
    assign o_signal_busy = r_out.busy;

    // skid entry only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty result register");

    // pattern timer frozen while a one-shot plays
    a_pat_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_sig_active) |=> $stable(r_pat_timer))
        else $error("pattern timer moved during a one-shot");

    // valid trigger restarts the signal timer
    a_trigger_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_operation == OP_TRIGGER && i_signal_kind <= SIG_ERR1)
        |=> (r_sig_active && r_sig_timer == '0))
        else $error("trigger did not restart the one-shot");

    // signal timer never runs more than one past the longest one-shot length
    a_timer_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sig_timer <= LEN_ERR1 + 7'd1)
        else $error("signal timer out of range");

endmodule

>>> bench/tb_led_buzzer_pattern_generator_unit.sv
// self-checking bench for the led and buzzer pattern generator unit
module tb_led_buzzer_pattern_generator_unit;
    import lbpg_pkg::*;

    // mode and kind codes outside the named sets
    localparam logic [2:0] MODE_ALIAS_HI  = 3'd7;
    localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [2:0] KIND_UNUSED_MD = 3'd6;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

    localparam int N_PHASES    = 7;
    localparam int HOLD_CYCLES = 64;
    localparam int PHASE_ITEMS    [N_PHASES] = '{40, 40, 30, 30, 128, 128, 50};
    localparam int PHASE_TRIG_PCT [N_PHASES] = '{4, 4, 5, 8, 0, 0, 10};

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ADDR_W-1:0]   paddr         = '0;
    logic [DATA_W-1:0]   pwdata        = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_valid       = 1'b0;
    logic                o_stall;
    logic                i_operation   = 1'b0;
    logic [2:0]          i_signal_kind = 3'd0;
    logic                o_valid;
    logic                i_stall       = 1'b0;
    logic [PCT_W-1:0]    o_led_red;
    logic [PCT_W-1:0]    o_led_green;
    logic [PCT_W-1:0]    o_led_blue;
    logic                o_buzzer_on;
    logic [FREQ_W-1:0]   o_buzzer_freq;
    logic                o_signal_busy;

    led_buzzer_pattern_generator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_signal_kind (i_signal_kind),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_led_red     (o_led_red),
        .o_led_green   (o_led_green),
        .o_led_blue    (o_led_blue),
        .o_buzzer_on   (o_buzzer_on),
        .o_buzzer_freq (o_buzzer_freq),
        .o_signal_busy (o_signal_busy)
    );

    // shadow configuration
    logic [2:0]        cfg_mode    = MODE_PROCESSING1;
    logic [PCT_W-1:0]  cfg_red     = '0;
    logic [PCT_W-1:0]  cfg_green   = '0;
    logic [PCT_W-1:0]  cfg_blue    = '0;
    logic              cfg_buz_on  = 1'b0;
    logic [FREQ_W-1:0] cfg_freq    = '0;

    // shadow state of the lights and buzzer
    logic              sig_active  = 1'b0;
    logic [STIM_W-1:0] sig_timer   = '0;
    t_sig_kind         sig_held    = SIG_START1;
    logic [PTIM_W-1:0] pat_timer   = '0;
    logic [PCT_W-1:0]  drv_red     = '0;
    logic [PCT_W-1:0]  drv_green   = '0;
    logic [PCT_W-1:0]  drv_blue    = '0;
    logic              drv_buz     = 1'b0;
    logic [FREQ_W-1:0] drv_freq    = '0;

    t_result pending_drives[$];

    int errors        = 0;
    int beats_checked = 0;
    int n_triggers    = 0;
    int n_sig_ends    = 0;
    int n_wraps       = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_cnt      = 0;

    // directed table row: either a register write or one input beat
    typedef struct {
        bit          is_cfg;
        t_reg_idx    idx;
        logic [31:0] val;
        t_op         op;
        logic [2:0]  kind;
        bit          typed;
        t_result     want;
    } t_row;

    t_row directed_rows[$];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #(8 * 200000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random stall, or a long counted hold-off when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cnt != 0) begin
                i_stall <= 1'b1;
                hold_cnt--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    function automatic logic [PCT_W-1:0] clip_pct(int unsigned v);
        return (v > 100) ? PCT_FULL : PCT_W'(v);
    endfunction

    function automatic void set_rgb(int unsigned r, int unsigned g, int unsigned b);
        drv_red   = clip_pct(r);
        drv_green = clip_pct(g);
        drv_blue  = clip_pct(b);
    endfunction

    function automatic void set_buz(logic on, logic [FREQ_W-1:0] f);
        drv_buz  = on;
        drv_freq = f;
    endfunction

    // one input beat through the shadow state, returns the drives after it
    function automatic t_result advance_lights(t_op op, logic [2:0] kind);
        int unsigned t;
        int unsigned c;
        int unsigned len;
        t_result r;
        if (op == OP_TRIGGER) begin
            if (kind <= SIG_ERR1) begin
                sig_timer  = '0;
                sig_held   = t_sig_kind'(kind);
                sig_active = 1'b1;
                n_triggers++;
            end
        end else if (sig_active) begin
            t = 32'(sig_timer);
            case (sig_held)
                SIG_START1:    len = 32'(LEN_START1);
                SIG_START2:    len = 32'(LEN_START2);
                SIG_CONTINUE1: len = 32'(LEN_CONTINUE1);
                SIG_SUCCESS1:  len = 32'(LEN_SUCCESS1);
                default:       len = 32'(LEN_ERR1);
            endcase
            if (t > len) begin
                // end of the one-shot: drives hold
                sig_active = 1'b0;
                n_sig_ends++;
            end else begin
                case (sig_held)
                    SIG_START1: begin
                        if (t < 15) begin set_buz(1'b1, FREQ_900);  set_rgb(0, 0, 100); end
                        else        begin set_buz(1'b1, FREQ_1500); set_rgb(0, 100, 0); end
                    end
                    SIG_START2: begin
                        if (t < 15)      begin set_buz(1'b1, FREQ_800);  set_rgb(100, 0, 0); end
                        else if (t < 30) begin set_buz(1'b1, FREQ_1000); set_rgb(0, 100, 0); end
                        else             begin set_buz(1'b1, FREQ_1200); set_rgb(0, 0, 100); end
                    end
                    SIG_CONTINUE1: begin
                        drv_freq = FREQ_1500;
                        if (t < 20)      begin set_rgb(0, 0, 100); drv_buz = 1'b1; end
                        else if (t < 40) begin set_rgb(0, 0, 0);   drv_buz = 1'b0; end
                        else if (t < 60) set_rgb(0, 0, 100);
                        else             set_rgb(0, 0, 0);
                    end
                    SIG_SUCCESS1: begin
                        drv_freq = FREQ_1500;
                        if (t < 20)      begin set_rgb(0, 100, 0); drv_buz = 1'b1; end
                        else if (t < 40) begin set_rgb(0, 0, 0);   drv_buz = 1'b0; end
                        else if (t < 60) begin set_rgb(0, 100, 0); drv_buz = 1'b1; end
                        else             begin set_rgb(0, 0, 0);   drv_buz = 1'b0; end
                    end
                    default: begin
                        set_buz(1'b1, FREQ_800);
                        if (t < 25 || (t >= 50 && t < 75)) set_rgb(100, 0, 0);
                        else                                set_rgb(0, 0, 0);
                    end
                endcase
                sig_timer = STIM_W'(t + 1);
            end
        end else begin
            // background pattern on the free timer
            c = 32'(pat_timer);
            case (cfg_mode)
                MODE_NORMAL: begin
                    if (c > 200) c = 0;
                    drv_buz = 1'b0;
                    if (c < 100) set_rgb(0, c, 0);
                    else         set_rgb(0, 200 - c, 0);
                end
                MODE_FLYING: begin
                    if (c > 140) c = 0;
                    drv_buz = 1'b0;
                    if (c < 100)      set_rgb(0, (30 * c) / 100, (30 * (100 - c)) / 100);
                    else if (c < 110) set_rgb(0, 0, 100);
                    else if (c < 120) set_rgb(0, 0, 0);
                    else if (c < 130) set_rgb(0, 0, 100);
                    else              set_rgb(0, 0, 0);
                end
                MODE_PROCESSING1: begin
                    if (c > 50) c = 0;
                    drv_buz = 1'b0;
                    set_rgb(0, 0, 2 * c);
                end
                MODE_PROCESSING2: begin
                    if (c > 50) c = 0;
                    drv_buz = 1'b0;
                    if (c < 25) set_rgb(0, 100 - 4 * c, 4 * c);
                    else        set_rgb(0, 4 * (c - 25), 100 - 4 * (c - 25));
                end
                default: begin
                    if (cfg_buz_on) drv_freq = cfg_freq;
                    drv_buz = cfg_buz_on;
                    set_rgb(32'(cfg_red), 32'(cfg_green), 32'(cfg_blue));
                    if (c == 255) n_wraps++;
                end
            endcase
            pat_timer = PTIM_W'(c + 1);
        end
        r.red    = drv_red;
        r.green  = drv_green;
        r.blue   = drv_blue;
        r.buz_on = drv_buz;
        r.freq   = drv_freq;
        r.busy   = sig_active;
        return r;
    endfunction

    function automatic t_result drives(int r, int g, int b, bit on, int f, bit busy);
        t_result d;
        d.red    = PCT_W'(r);
        d.green  = PCT_W'(g);
        d.blue   = PCT_W'(b);
        d.buz_on = on;
        d.freq   = FREQ_W'(f);
        d.busy   = busy;
        return d;
    endfunction

    function automatic void cfg_row(t_reg_idx idx, logic [31:0] val);
        t_row row;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.val    = val;
        directed_rows.push_back(row);
    endfunction

    function automatic void item_row(t_op op, logic [2:0] kind, bit typed, t_result want);
        t_row row;
        row.is_cfg = 1'b0;
        row.op     = op;
        row.kind   = kind;
        row.typed  = typed;
        row.want   = want;
        directed_rows.push_back(row);
    endfunction

    // register write: setup then access, pready is always high
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PATTERN_MODE:  cfg_mode   = val[2:0];
            REG_MANUAL_RED:    cfg_red    = val[PCT_W-1:0];
            REG_MANUAL_GREEN:  cfg_green  = val[PCT_W-1:0];
            REG_MANUAL_BLUE:   cfg_blue   = val[PCT_W-1:0];
            REG_MANUAL_BUZ_ON: cfg_buz_on = val[0];
            REG_MANUAL_FREQ:   cfg_freq   = val[FREQ_W-1:0];
            default: ;
        endcase
    endtask

    // stop offering beats and wait until every result is back
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // offer one beat, return the shadow drives once it is taken
    task automatic send_beat(input t_op op, input logic [2:0] kind, output t_result pred);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_signal_kind <= kind;
        do @(posedge i_clk); while (o_stall);
        pred = advance_lights(op, kind);
    endtask

    // result checking against the oldest expectation
    always @(posedge i_clk) begin : beat_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_drives.size() == 0) begin
                $error("result beat with no expectation waiting");
                errors++;
            end else begin
                want = pending_drives.pop_front();
                beats_checked++;
                if (o_led_red !== want.red) begin
                    $error("led_red: expected %0d, got %0d", want.red, o_led_red);
                    errors++;
                end
                if (o_led_green !== want.green) begin
                    $error("led_green: expected %0d, got %0d", want.green, o_led_green);
                    errors++;
                end
                if (o_led_blue !== want.blue) begin
                    $error("led_blue: expected %0d, got %0d", want.blue, o_led_blue);
                    errors++;
                end
                if (o_buzzer_on !== want.buz_on) begin
                    $error("buzzer_on: expected %0d, got %0d", want.buz_on, o_buzzer_on);
                    errors++;
                end
                if (o_buzzer_freq !== want.freq) begin
                    $error("buzzer_freq: expected %0d, got %0d", want.freq, o_buzzer_freq);
                    errors++;
                end
                if (o_signal_busy !== want.busy) begin
                    $error("signal_busy: expected %0d, got %0d", want.busy, o_signal_busy);
                    errors++;
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_result pred;
        t_row    row;
        int      mode_code;
        int      kind_pick;
        int      wait_n;

        // directed table: reset state, manual extremes, every one-shot, ignored kinds
        item_row(OP_TICK, 3'd0, 1'b1, drives(0, 0, 0, 0, 0, 0));
        item_row(OP_TICK, 3'd0, 1'b1, drives(0, 0, 2, 0, 0, 0));
        cfg_row(REG_PATTERN_MODE, 32'(MODE_MANUAL));
        cfg_row(REG_MANUAL_RED, 32'h7F);
        cfg_row(REG_MANUAL_GREEN, 32'(PCT_FULL));
        cfg_row(REG_MANUAL_BLUE, 32'd0);
        cfg_row(REG_MANUAL_BUZ_ON, 32'd1);
        cfg_row(REG_MANUAL_FREQ, 32'hFFFF);
        item_row(OP_TICK, 3'd7, 1'b1, drives(100, 100, 0, 1, 65535, 0));
        cfg_row(REG_MANUAL_BUZ_ON, 32'd0);
        cfg_row(REG_MANUAL_FREQ, 32'd0);
        item_row(OP_TICK, 3'd0, 1'b1, drives(100, 100, 0, 0, 65535, 0));
        cfg_row(REG_PATTERN_MODE, 32'(MODE_ALIAS_HI));
        cfg_row(REG_MANUAL_RED, 32'd0);
        cfg_row(REG_MANUAL_BLUE, 32'h7F);
        item_row(OP_TICK, 3'd0, 1'b1, drives(0, 100, 100, 0, 65535, 0));
        item_row(OP_TRIGGER, KIND_UNUSED_LO, 1'b1, drives(0, 100, 100, 0, 65535, 0));
        item_row(OP_TRIGGER, SIG_START1, 1'b1, drives(0, 100, 100, 0, 65535, 1));
        item_row(OP_TICK, 3'd0, 1'b1, drives(0, 0, 100, 1, 900, 1));
        item_row(OP_TRIGGER, SIG_START2, 1'b1, drives(0, 0, 100, 1, 900, 1));
        item_row(OP_TICK, 3'd0, 1'b1, drives(100, 0, 0, 1, 800, 1));
        item_row(OP_TRIGGER, SIG_CONTINUE1, 1'b1, drives(100, 0, 0, 1, 800, 1));
        item_row(OP_TICK, 3'd0, 1'b1, drives(0, 0, 100, 1, 1500, 1));
        item_row(OP_TRIGGER, SIG_SUCCESS1, 1'b1, drives(0, 0, 100, 1, 1500, 1));
        item_row(OP_TICK, 3'd0, 1'b1, drives(0, 100, 0, 1, 1500, 1));
        item_row(OP_TRIGGER, SIG_ERR1, 1'b1, drives(0, 100, 0, 1, 1500, 1));
        item_row(OP_TICK, 3'd0, 1'b1, drives(100, 0, 0, 1, 800, 1));
        item_row(OP_TRIGGER, KIND_UNUSED_MD, 1'b1, drives(100, 0, 0, 1, 800, 1));
        item_row(OP_TRIGGER, KIND_UNUSED_HI, 1'b0, pred);
        item_row(OP_TICK, 3'd7, 1'b0, pred);
        item_row(OP_TICK, 3'd0, 1'b0, pred);

        // hold reset, then release it
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                settle();
                write_reg(row.idx, row.val);
            end else begin
                send_beat(row.op, row.kind, pred);
                pending_drives.push_back(row.typed ? row.want : pred);
            end
        end

        // random phases over the background modes and idling patterns
        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 75; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 75; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            case (p)
                0: mode_code = int'(MODE_NORMAL);
                1: mode_code = int'(MODE_FLYING);
                2: mode_code = int'(MODE_PROCESSING2);
                3: mode_code = int'(MODE_PROCESSING1);
                4: mode_code = int'(MODE_MANUAL);
                5: mode_code = $urandom_range(MODE_MANUAL, MODE_ALIAS_HI);
                default: mode_code = $urandom_range(0, MODE_ALIAS_HI);
            endcase
            write_reg(REG_PATTERN_MODE, 32'(mode_code));
            if (mode_code >= MODE_MANUAL) begin
                write_reg(REG_MANUAL_RED, $urandom_range(0, 127));
                write_reg(REG_MANUAL_GREEN, $urandom_range(0, 127));
                write_reg(REG_MANUAL_BLUE, $urandom_range(0, 127));
                write_reg(REG_MANUAL_BUZ_ON, $urandom_range(0, 1));
                write_reg(REG_MANUAL_FREQ, $urandom_range(0, 65535));
            end
            // long receiver hold-off while beats keep coming, fills the block
            if (p == 0) hold_cnt = HOLD_CYCLES;
            // trigger-free phases first play out any running one-shot
            if (PHASE_TRIG_PCT[p] == 0) begin
                while (sig_active) begin
                    send_beat(OP_TICK, 3'($urandom_range(0, 7)), pred);
                    pending_drives.push_back(pred);
                end
            end
            for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
                if ($urandom_range(0, 99) < PHASE_TRIG_PCT[p]) begin
                    kind_pick = ($urandom_range(0, 99) < 85) ? $urandom_range(0, SIG_ERR1)
                                                             : $urandom_range(KIND_UNUSED_LO,
                                                                              KIND_UNUSED_HI);
                    send_beat(OP_TRIGGER, 3'(kind_pick), pred);
                end else begin
                    send_beat(OP_TICK, 3'($urandom_range(0, 7)), pred);
                end
                pending_drives.push_back(pred);
            end
        end

        // drain, then keep watching for stray beats
        i_valid <= 1'b0;
        wait_n = 0;
        while (pending_drives.size() != 0 && wait_n < 5000) begin
            @(posedge i_clk);
            wait_n++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_drives.size() != 0) begin
            $error("%0d expected result beats never arrived", pending_drives.size());
            errors += pending_drives.size();
        end

        $display("checked %0d result beats over %0d random phases plus the directed table",
                 beats_checked, N_PHASES);
        $display("%0d one-shots started, %0d played out, %0d manual timer wraps",
                 n_triggers, n_sig_ends, n_wraps);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
